// ===== hdl/median_filter_3x3_assert.svh =====
// ----------------------------------------------------------------------------
// median_filter_3x3 assertion macros
// Clocked assertion helpers for the median filter; they compile away when
// SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef MEDIAN_FILTER_3X3_ASSERT_SVH
`define MEDIAN_FILTER_3X3_ASSERT_SVH
`ifndef SYNTH
// property must hold at every edge outside reset
`define MF3_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// condition must never be seen outside reset
`define MF3_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define MF3_ASSERT(lbl, prop, msg)
`define MF3_NEVER(lbl, cond, msg)
`endif
`endif

// ===== hdl/mf3_pkg.sv =====
// ----------------------------------------------------------------------------
// mf3_pkg
// Shared constants, types and small helper functions of the 3x3 median filter.
// ----------------------------------------------------------------------------
`default_nettype none

package mf3_pkg;

	localparam int MAX_WIDTH  = 2048;
	localparam int PIX_W      = 8;
	localparam int ROW_W      = 16;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int OUT_COL_W  = 11;
	localparam int IMG_W_W    = 12;
	localparam int IMG_H_W    = 16;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 1;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

	localparam int RESET_WIDTH  = 640;
	localparam int RESET_HEIGHT = 480;

	localparam int WIN_N = 9;

	// result slots of one input pixel, in emission order
	localparam int SLOT_N      = 4;
	localparam int SLOT_CENTER = 0;
	localparam int SLOT_RIGHT  = 1;
	localparam int SLOT_BELOW  = 2;
	localparam int SLOT_CORNER = 3;

	localparam int FIFO_DEPTH = 8;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	typedef logic [PIX_W-1:0] pix_t;

	typedef struct packed {
		pix_t [SLOT_N-1:0]   pix;
		logic [ROW_W-1:0]    row;
		logic [COL_W-1:0]    col;
		logic [SLOT_N-1:0]   mask;
	} mf3_job_t;

	function automatic pix_t min2(input pix_t a, input pix_t b);
		return (a < b) ? a : b;
	endfunction

	function automatic pix_t max2(input pix_t a, input pix_t b);
		return (a < b) ? b : a;
	endfunction

	function automatic pix_t min3(input pix_t a, input pix_t b, input pix_t c);
		return min2(min2(a, b), c);
	endfunction

	function automatic pix_t max3(input pix_t a, input pix_t b, input pix_t c);
		return max2(max2(a, b), c);
	endfunction

	function automatic pix_t med3(input pix_t a, input pix_t b, input pix_t c);
		return max2(min2(a, b), min2(max2(a, b), c));
	endfunction

	// last column index after clamping the width into [3, MAX_WIDTH]
	function automatic logic [COL_W-1:0] width_last(input logic [IMG_W_W-1:0] iw);
		if (iw < IMG_W_W'(3)) begin
			return COL_W'(2);
		end else if (32'(iw) > MAX_WIDTH) begin
			return COL_W'(MAX_WIDTH - 1);
		end else begin
			return COL_W'(iw - IMG_W_W'(1));
		end
	endfunction

	// last row index after raising the height to at least 3
	function automatic logic [ROW_W-1:0] height_last(input logic [IMG_H_W-1:0] ih);
		if (ih < IMG_H_W'(3)) begin
			return ROW_W'(2);
		end else begin
			return ROW_W'(ih - IMG_H_W'(1));
		end
	endfunction

endpackage

`default_nettype wire

// ===== hdl/mf3_median.sv =====
// ----------------------------------------------------------------------------
// mf3_median
// Three-stage median-of-nine network: column sort, row reduce, final median.
// ----------------------------------------------------------------------------
`default_nettype none

module mf3_median import mf3_pkg::*; (
	input  logic               clk,
	input  pix_t [WIN_N-1:0]   win,
	output pix_t               med
);

	pix_t [2:0] mn_s2;
	pix_t [2:0] md_s2;
	pix_t [2:0] mx_s2;
	pix_t       lo_s3;
	pix_t       mid_s3;
	pix_t       hi_s3;
	pix_t       med_s4;

	always_ff @(posedge clk) begin
		// sort each column of three
		for (int k = 0; k < 3; k++) begin
			mn_s2[k] <= min3(win[k], win[3 + k], win[6 + k]);
			md_s2[k] <= med3(win[k], win[3 + k], win[6 + k]);
			mx_s2[k] <= max3(win[k], win[3 + k], win[6 + k]);
		end
		lo_s3  <= max3(mn_s2[0], mn_s2[1], mn_s2[2]);
		mid_s3 <= med3(md_s2[0], md_s2[1], md_s2[2]);
		hi_s3  <= min3(mx_s2[0], mx_s2[1], mx_s2[2]);
		med_s4 <= med3(lo_s3, mid_s3, hi_s3);
	end

	assign med = med_s4;

endmodule

`default_nettype wire

// ===== hdl/mf3_front.sv =====
// ----------------------------------------------------------------------------
// mf3_front
// Pixel intake: geometry registers, raster counters, line store, window and
// median pipeline; pushes one job per pixel that yields results.
// ----------------------------------------------------------------------------
`default_nettype none

module mf3_front import mf3_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  pix_t                  pixel_in,
	input  logic [FIFO_CNT_W-1:0] q_count,
	output logic                  push,
	output mf3_job_t              push_job
);

	logic [COL_W-1:0]  wm1_q;
	logic [ROW_W-1:0]  hm1_q;
	logic [ROW_W-1:0]  row_q;
	logic [COL_W-1:0]  col_q;

	logic [ROW_W-1:0]  r_cur;
	logic [COL_W-1:0]  c_cur;
	logic              last_col;
	logic              last_row;
	logic [SLOT_N-1:0] mask_cur;
	logic              interior_cur;
	logic              accept;

	logic [FIFO_CNT_W:0] inflight;
	logic [FIFO_CNT_W:0] used;

	// line store entry: {older row, newer row}
	logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];

	logic               valid_s1, valid_s2, valid_s3, valid_s4;
	pix_t               pix_s1;
	logic [ROW_W-1:0]   row_s1, row_s2, row_s3, row_s4;
	logic [COL_W-1:0]   col_s1, col_s2, col_s3, col_s4;
	logic [SLOT_N-1:0]  mask_s1, mask_s2, mask_s3, mask_s4;
	logic               interior_s1, interior_s2, interior_s3, interior_s4;
	logic [2*PIX_W-1:0] rd_s1;
	logic               byp_s1;
	logic [2*PIX_W-1:0] byp_data_s1;
	pix_t [SLOT_N-1:0]  border_s2, border_s3, border_s4;

	logic [2*PIX_W-1:0] line_rd;
	pix_t               older_rd;
	pix_t               newer_rd;
	pix_t [WIN_N-1:0]   win_q;
	pix_t [WIN_N-1:0]   win_new;
	pix_t               med_s4;

	// position of the arriving pixel, clamped to the current geometry
	always_comb begin
		r_cur        = (row_q < hm1_q) ? row_q : hm1_q;
		c_cur        = (col_q < wm1_q) ? col_q : wm1_q;
		last_col     = (c_cur == wm1_q);
		last_row     = (r_cur == hm1_q);
		mask_cur[SLOT_CENTER] = (r_cur != '0) && (c_cur != '0);
		mask_cur[SLOT_RIGHT]  = (r_cur != '0) && last_col;
		mask_cur[SLOT_BELOW]  = last_row && (c_cur != '0);
		mask_cur[SLOT_CORNER] = last_row && last_col;
		interior_cur = (r_cur >= ROW_W'(2)) && (c_cur >= COL_W'(2));
	end

	// credit check: queue fill plus every job still in the pipe
	assign inflight = {{FIFO_CNT_W{1'b0}}, valid_s1} + {{FIFO_CNT_W{1'b0}}, valid_s2}
		+ {{FIFO_CNT_W{1'b0}}, valid_s3} + {{FIFO_CNT_W{1'b0}}, valid_s4};
	assign used     = {1'b0, q_count} + inflight;
	assign in_ready = used < (FIFO_CNT_W + 1)'(FIFO_DEPTH);
	assign accept   = in_valid && in_ready;

	// forward the entry written in the same edge as the read
	assign line_rd  = byp_s1 ? byp_data_s1 : rd_s1;
	assign older_rd = line_rd[2*PIX_W-1:PIX_W];
	assign newer_rd = line_rd[PIX_W-1:0];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			win_new[i*3 + 0] = win_q[i*3 + 1];
			win_new[i*3 + 1] = win_q[i*3 + 2];
		end
		win_new[2] = older_rd;
		win_new[5] = newer_rd;
		win_new[8] = pix_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wm1_q    <= COL_W'(RESET_WIDTH - 1);
			hm1_q    <= ROW_W'(RESET_HEIGHT - 1);
			row_q    <= '0;
			col_q    <= '0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			win_q    <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_IMAGE_WIDTH:  wm1_q <= width_last(cfg_data[IMG_W_W-1:0]);
					REG_IMAGE_HEIGHT: hm1_q <= height_last(cfg_data[IMG_H_W-1:0]);
				endcase
			end
			if (accept) begin
				if (last_col) begin
					col_q <= '0;
					row_q <= last_row ? '0 : r_cur + 1'b1;
				end else begin
					col_q <= c_cur + 1'b1;
					row_q <= r_cur;
				end
			end
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			if (valid_s1) begin
				win_q <= win_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1      <= pixel_in;
			row_s1      <= r_cur;
			col_s1      <= c_cur;
			mask_s1     <= mask_cur;
			interior_s1 <= interior_cur;
			rd_s1       <= line_mem[c_cur];
			byp_s1      <= valid_s1 && (col_s1 == c_cur);
			byp_data_s1 <= {newer_rd, pix_s1};
		end
		// age the column: newer row moves to older, new pixel becomes newer
		if (valid_s1) begin
			line_mem[col_s1] <= {newer_rd, pix_s1};
		end
		row_s2      <= row_s1;
		col_s2      <= col_s1;
		mask_s2     <= mask_s1;
		interior_s2 <= interior_s1;
		border_s2[SLOT_CENTER] <= win_new[4];
		border_s2[SLOT_RIGHT]  <= win_new[5];
		border_s2[SLOT_BELOW]  <= win_new[7];
		border_s2[SLOT_CORNER] <= win_new[8];
		row_s3      <= row_s2;
		col_s3      <= col_s2;
		mask_s3     <= mask_s2;
		interior_s3 <= interior_s2;
		border_s3   <= border_s2;
		row_s4      <= row_s3;
		col_s4      <= col_s3;
		mask_s4     <= mask_s3;
		interior_s4 <= interior_s3;
		border_s4   <= border_s3;
	end

	mf3_median u_median (
		.clk (clk),
		.win (win_new),
		.med (med_s4)
	);

	always_comb begin
		push_job.pix  = border_s4;
		push_job.row  = row_s4;
		push_job.col  = col_s4;
		push_job.mask = mask_s4;
		if (interior_s4) begin
			push_job.pix[SLOT_CENTER] = med_s4;
		end
	end

	// drop pixels that yield no result
	assign push = valid_s4 && (mask_s4 != '0);

endmodule

`default_nettype wire

// ===== hdl/mf3_fifo.sv =====
// ----------------------------------------------------------------------------
// mf3_fifo
// Short job queue between the pixel intake and the result emitter.
// ----------------------------------------------------------------------------
`default_nettype none
`include "median_filter_3x3_assert.svh"

module mf3_fifo import mf3_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  mf3_job_t              din,
	input  logic                  pop,
	output mf3_job_t              dout,
	output logic [FIFO_CNT_W-1:0] count
);

	mf3_job_t              entry_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_CNT_W-1:0] count_q;

	function automatic logic [FIFO_PTR_W-1:0] ptr_inc(input logic [FIFO_PTR_W-1:0] p);
		return (p == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= din;
		end
	end

	assign dout  = entry_q[rd_ptr_q];
	assign count = count_q;

	`MF3_NEVER(a_push_full, push && (count_q == FIFO_CNT_W'(FIFO_DEPTH)), "job pushed into full queue")
	`MF3_NEVER(a_pop_empty, pop && (count_q == '0), "job popped from empty queue")
	`MF3_ASSERT(a_count_up, push && !pop |=> count_q == $past(count_q) + 1'b1, "fill count missed a push")
	`MF3_ASSERT(a_count_down, pop && !push |=> count_q == $past(count_q) - 1'b1, "fill count missed a pop")

endmodule

`default_nettype wire

// ===== hdl/mf3_back.sv =====
// ----------------------------------------------------------------------------
// mf3_back
// Result emitter: expands one job into its one to four output beats.
// ----------------------------------------------------------------------------
`default_nettype none

module mf3_back import mf3_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [FIFO_CNT_W-1:0] q_count,
	input  mf3_job_t              q_job,
	output logic                  pop,
	output logic                  out_valid,
	input  logic                  out_ready,
	output pix_t                  pixel_out,
	output logic [ROW_W-1:0]      out_row,
	output logic [OUT_COL_W-1:0]  out_col,
	output logic                  run_last,
	output logic                  frame_last
);

	mf3_job_t              job_q;
	logic [SLOT_N-1:0]     rem_q;
	logic [SLOT_N-1:0]     cur_bit;
	logic [SLOT_N-1:0]     rem_next;
	logic                  load;

	pix_t                  res_pix;
	logic [ROW_W-1:0]      res_row;
	logic [COL_W-1:0]      res_col;

	logic                  out_valid_q;
	pix_t                  pixel_q;
	logic [ROW_W-1:0]      row_q;
	logic [OUT_COL_W-1:0]  col_q;
	logic                  run_last_q;
	logic                  frame_last_q;

	// lowest pending slot goes next
	assign cur_bit  = rem_q & (~rem_q + 1'b1);
	assign rem_next = rem_q & ~cur_bit;
	assign load     = (rem_q != '0) && (!out_valid_q || out_ready);
	assign pop      = (q_count != '0) && ((rem_q == '0) || (load && (rem_next == '0)));

	always_comb begin
		res_pix = job_q.pix[SLOT_CORNER];
		res_row = job_q.row;
		res_col = job_q.col;
		if (cur_bit[SLOT_CENTER]) begin
			res_pix = job_q.pix[SLOT_CENTER];
			res_row = job_q.row - 1'b1;
			res_col = job_q.col - 1'b1;
		end else if (cur_bit[SLOT_RIGHT]) begin
			res_pix = job_q.pix[SLOT_RIGHT];
			res_row = job_q.row - 1'b1;
		end else if (cur_bit[SLOT_BELOW]) begin
			res_pix = job_q.pix[SLOT_BELOW];
			res_col = job_q.col - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				rem_q <= q_job.mask;
			end else if (load) begin
				rem_q <= rem_next;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= q_job;
		end
		if (load) begin
			pixel_q      <= res_pix;
			row_q        <= res_row;
			col_q        <= OUT_COL_W'(res_col);
			run_last_q   <= (rem_next == '0);
			frame_last_q <= cur_bit[SLOT_CORNER];
		end
	end

	assign out_valid  = out_valid_q;
	assign pixel_out  = pixel_q;
	assign out_row    = row_q;
	assign out_col    = col_q;
	assign run_last   = run_last_q;
	assign frame_last = frame_last_q;

endmodule

`default_nettype wire

// ===== hdl/median_filter_3x3.sv =====
// ----------------------------------------------------------------------------
// median_filter_3x3
// 3x3 median filter over a raster stream of 8-bit pixels, one plane.
// ----------------------------------------------------------------------------
// Feed one pixel per beat in raster order; the block sustains one pixel per
// clock. Arriving pixel (r,c) yields output (r-1,c-1): the median of its 3x3
// neighbourhood when interior, the pixel itself on the first or last row or
// column. The last column also yields (r-1,W-1); the last row also yields
// (r,c-1), and its last column (r,W-1) with frame_last set, so one input
// gives zero to four result beats and run_last marks the final one. The
// result side emits one beat per clock while out_ready is high, so a pixel
// with k results holds that side for k beats; row ends and the last row
// drain from an 8-entry job queue while intake keeps running, and intake
// stalls only once the queue and the four intake stages together hold eight
// jobs. An input beat reaches its first result beat through the line store
// read on the accepting edge, three median network stages, queue write, job
// register and output register. The line store is one 2048 x 16 RAM (older
// and newer row per column) with one read port and one write port, read at
// intake and written in the cycle after, so no clearing pass runs after
// reset; its contents are valid once the first two rows of a frame have
// passed. Write image_width (index 0) and image_height (index 1) only while
// idle; out-of-range values clamp to at least 3, widths to at most 2048.
`default_nettype none

module median_filter_3x3 import mf3_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration write port
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// pixel input
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [PIX_W-1:0]      pixel_in,
	// result output
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [PIX_W-1:0]      pixel_out,
	output logic [ROW_W-1:0]      out_row,
	output logic [OUT_COL_W-1:0]  out_col,
	output logic                  run_last,
	output logic                  frame_last
);

	logic                  push;
	logic                  pop;
	mf3_job_t              push_job;
	mf3_job_t              pop_job;
	logic [FIFO_CNT_W-1:0] q_count;

	// intake: counters, line store, window, median pipe
	mf3_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.pixel_in  (pixel_in),
		.q_count   (q_count),
		.push      (push),
		.push_job  (push_job)
	);

	// decouple intake from result emission
	mf3_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (push_job),
		.pop    (pop),
		.dout   (pop_job),
		.count  (q_count)
	);

	// emit each job's result beats in order
	mf3_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_count    (q_count),
		.q_job      (pop_job),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.pixel_out  (pixel_out),
		.out_row    (out_row),
		.out_col    (out_col),
		.run_last   (run_last),
		.frame_last (frame_last)
	);

endmodule

`default_nettype wire

// ===== tb/median_filter_3x3_test.sv =====
// ----------------------------------------------------------------------------
// median_filter_3x3_test
// Self-checking bench for the 3x3 median filter. Streams raster frames of many
// geometries through the pixel port, predicts every result beat and compares
// the output beats in order, field by field.
// ----------------------------------------------------------------------------

import mf3_pkg::*;

class median_tracker;
	typedef struct {
		pix_t                 pix;
		logic [ROW_W-1:0]     row;
		logic [OUT_COL_W-1:0] col;
		logic                 run_last;
		logic                 frame_last;
	} out_beat_t;

	logic [IMG_W_W-1:0] width_reg;
	logic [IMG_H_W-1:0] height_reg;
	pix_t               older_row [MAX_WIDTH];
	pix_t               newer_row [MAX_WIDTH];
	pix_t               win [3][3];
	int unsigned        row_cnt;
	int unsigned        col_cnt;
	out_beat_t          due_beats [$];
	int unsigned        errors;
	int unsigned        beats_seen;
	int unsigned        medians;
	int unsigned        pixels;
	int unsigned        frames;

	function new();
		width_reg  = IMG_W_W'(RESET_WIDTH);
		height_reg = IMG_H_W'(RESET_HEIGHT);
		for (int i = 0; i < MAX_WIDTH; i++) begin
			older_row[i] = '0;
			newer_row[i] = '0;
		end
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				win[i][j] = '0;
			end
		end
		row_cnt = 0;
		col_cnt = 0;
	endfunction

	function void set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		if (idx == REG_IMAGE_WIDTH) begin
			width_reg = data[IMG_W_W-1:0];
		end else if (idx == REG_IMAGE_HEIGHT) begin
			height_reg = data[IMG_H_W-1:0];
		end
	endfunction

	function int unsigned last_col_idx();
		if (width_reg < 3) return 2;
		if (int'(width_reg) > MAX_WIDTH) return MAX_WIDTH - 1;
		return int'(width_reg) - 1;
	endfunction

	function int unsigned last_row_idx();
		if (height_reg < 3) return 2;
		return int'(height_reg) - 1;
	endfunction

	function bit at_frame_start();
		return row_cnt == 0 && col_cnt == 0;
	endfunction

	function int unsigned waiting();
		return due_beats.size();
	endfunction

	function pix_t median_of_window();
		pix_t v [9];
		pix_t t;
		int   m;
		for (int k = 0; k < 9; k++) v[k] = win[k / 3][k % 3];
		for (int k = 1; k < 9; k++) begin
			t = v[k];
			for (m = k; m > 0 && v[m-1] > t; m--) v[m] = v[m-1];
			v[m] = t;
		end
		return v[4];
	endfunction

	function void add_beat(input pix_t p, input int unsigned r, input int unsigned c,
			input bit more, input bit fl);
		out_beat_t b;
		b.pix        = p;
		b.row        = ROW_W'(r);
		b.col        = OUT_COL_W'(c);
		b.run_last   = !more;
		b.frame_last = fl;
		due_beats.push_back(b);
	endfunction

	// advance the window by one accepted pixel and queue the beats it causes
	function void take_pixel(input pix_t p);
		int unsigned wl, hl, r, c;
		bit          on_last_col, on_last_row;
		bit          emit_center, emit_right, emit_below, emit_corner;
		pix_t        center;
		wl = last_col_idx();
		hl = last_row_idx();
		r  = (row_cnt < hl) ? row_cnt : hl;
		c  = (col_cnt < wl) ? col_cnt : wl;
		on_last_col = (c == wl);
		on_last_row = (r == hl);
		for (int k = 0; k < 3; k++) begin
			win[k][0] = win[k][1];
			win[k][1] = win[k][2];
		end
		win[0][2]    = older_row[c];
		win[1][2]    = newer_row[c];
		win[2][2]    = p;
		older_row[c] = newer_row[c];
		newer_row[c] = p;
		emit_center = (r >= 1) && (c >= 1);
		emit_right  = (r >= 1) && on_last_col;
		emit_below  = on_last_row && (c >= 1);
		emit_corner = on_last_row && on_last_col;
		if (emit_center) begin
			if (r >= 2 && c >= 2) begin
				center = median_of_window();
				medians++;
			end else begin
				center = win[1][1];
			end
			add_beat(center, r - 1, c - 1, emit_right || emit_below || emit_corner, 1'b0);
		end
		if (emit_right) add_beat(win[1][2], r - 1, c, emit_below || emit_corner, 1'b0);
		if (emit_below) add_beat(win[2][1], r, c - 1, emit_corner, 1'b0);
		if (emit_corner) begin
			add_beat(win[2][2], r, c, 1'b0, 1'b1);
			frames++;
		end
		pixels++;
		if (on_last_col) begin
			col_cnt = 0;
			row_cnt = on_last_row ? 0 : r + 1;
		end else begin
			col_cnt = c + 1;
			row_cnt = r;
		end
	endfunction

	task flag_mismatch(input string what);
		errors++;
		$display("[%0t] mismatch: %s", $time, what);
	endtask

	task match_beat(input pix_t p, input logic [ROW_W-1:0] r, input logic [OUT_COL_W-1:0] c,
			input logic rl, input logic fl);
		out_beat_t e;
		beats_seen++;
		if (due_beats.size() == 0) begin
			flag_mismatch($sformatf("beat (%0d,%0d)=%0d with nothing expected", r, c, p));
			return;
		end
		e = due_beats.pop_front();
		if (p !== e.pix)
			flag_mismatch($sformatf("pixel_out at (%0d,%0d): got %0d, want %0d",
				e.row, e.col, p, e.pix));
		if (r !== e.row)
			flag_mismatch($sformatf("out_row: got %0d, want %0d", r, e.row));
		if (c !== e.col)
			flag_mismatch($sformatf("out_col at row %0d: got %0d, want %0d", e.row, c, e.col));
		if (rl !== e.run_last)
			flag_mismatch($sformatf("run_last at (%0d,%0d): got %b, want %b",
				e.row, e.col, rl, e.run_last));
		if (fl !== e.frame_last)
			flag_mismatch($sformatf("frame_last at (%0d,%0d): got %b, want %b",
				e.row, e.col, fl, e.frame_last));
	endtask
endclass

module median_filter_3x3_test;

	localparam int HALF_PERIOD     = 5;
	localparam int RESET_CYCLES    = 7;
	localparam int SETTLE_CYCLES   = 12;    // above the pipeline depth, with margin
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int QUIET_LIMIT     = 2000;  // well above the longest hold-off
	localparam int RANDOM_PIXELS   = 500;
	localparam int IDLE_PCT        = 22;
	localparam int PAD_W           = CFG_DATA_W - IMG_W_W;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_ready;
	logic [PIX_W-1:0]      pixel_in;
	logic                  out_valid;
	logic                  out_ready;
	logic [PIX_W-1:0]      pixel_out;
	logic [ROW_W-1:0]      out_row;
	logic [OUT_COL_W-1:0]  out_col;
	logic                  run_last;
	logic                  frame_last;

	median_tracker tracker;
	bit            steady;        // both sides run flat out while set
	bit            hold_due;      // asks the result side for one long hold-off
	int unsigned   quiet_cycles;
	int unsigned   random_pixels;

	always #HALF_PERIOD clk = ~clk;

	median_filter_3x3 DUT (.*);

	// Offer one pixel beat, with a random idle gap in front, and hold it until
	// the block takes it; then feed it to the tracker.
	task automatic send_pixel(input pix_t pix);
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		pixel_in <= pix;
		do @(posedge clk); while (!in_ready);
		tracker.take_pixel(pix);
	endtask

	// Drop valid, drain every expected beat, then give pixels that cause no
	// result time to leave the pipeline.
	task automatic settle();
		in_valid <= 1'b0;
		while (tracker.waiting() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write width and/or height once the block is idle.
	task automatic write_geometry(input bit set_w, input logic [CFG_DATA_W-1:0] w_val,
			input bit set_h, input logic [CFG_DATA_W-1:0] h_val);
		settle();
		if (set_w) begin
			cfg_we    <= 1'b1;
			cfg_index <= REG_IMAGE_WIDTH;
			cfg_data  <= w_val;
			@(posedge clk);
			tracker.set_reg(REG_IMAGE_WIDTH, w_val);
		end
		if (set_h) begin
			cfg_we    <= 1'b1;
			cfg_index <= REG_IMAGE_HEIGHT;
			cfg_data  <= h_val;
			@(posedge clk);
			tracker.set_reg(REG_IMAGE_HEIGHT, h_val);
		end
		cfg_we <= 1'b0;
	endtask

	// Width value with junk in the unused upper bits: mostly 3..12, some below
	// the floor, and (when allowed) wide values up to the 12-bit maximum.
	function automatic logic [CFG_DATA_W-1:0] pick_width(input bit allow_wide);
		logic [IMG_W_W-1:0] w;
		int unsigned        k;
		k = $urandom_range(99);
		if (allow_wide && k < 12) w = IMG_W_W'($urandom_range(4095, 13));
		else if (k < 22) w = IMG_W_W'($urandom_range(2));
		else w = IMG_W_W'($urandom_range(12, 3));
		return {PAD_W'($urandom), w};
	endfunction

	// Height value: mostly 3..8, some below the floor, now and then very tall.
	function automatic logic [CFG_DATA_W-1:0] pick_height(input bit allow_tall);
		int unsigned k;
		k = $urandom_range(99);
		if (allow_tall && k < 10) return CFG_DATA_W'($urandom_range(65535, 21));
		if (k < 20) return CFG_DATA_W'($urandom_range(2));
		return CFG_DATA_W'($urandom_range(8, 3));
	endfunction

	// Result side: take and check beats, stall at random, and serve one long
	// hold-off whenever the stimulus asks for it.
	initial begin
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				tracker.match_beat(pixel_out, out_row, out_col, run_last, frame_last);
			if (hold_due) begin
				hold_due = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
			end
			out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// Watchdog: end the run when no beat moves on either side for too long.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("[%0t] no beat accepted for %0d cycles", $time, QUIET_LIMIT);
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		pix_t        pix;
		int unsigned wide_cut;
		int unsigned tall_cut;
		tracker   = new();
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		in_valid  = 1'b0;
		pixel_in  = '0;
		steady    = 1'b0;
		hold_due  = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset geometry (640 x 480): a few pixels of row 0, value extremes.
		send_pixel(8'h00);
		send_pixel(8'hFF);
		send_pixel(8'h55);
		send_pixel(8'hAA);
		// Grow to the full line store while still in row 0; upper data bits set.
		write_geometry(1'b1, 16'hF800, 1'b0, '0);
		send_pixel(8'h01);
		send_pixel(8'h80);
		send_pixel(8'hFE);
		// Below-floor width and height mid-row: the column count clamps to the
		// new last column, row 0 closes at once and the frame ends as 3 x 3.
		write_geometry(1'b1, 16'h0002, 1'b1, 16'h0001);
		for (int k = 0; k < 7; k++) send_pixel((k % 2) ? 8'hFF : 8'h00);
		// Tallest height at the narrowest width, then cut the height deep in the
		// frame so the current row becomes the last one.
		write_geometry(1'b1, 16'h0003, 1'b1, 16'hFFFF);
		for (int k = 0; k < 12; k++) send_pixel(pix_t'($urandom_range(1) * 255));
		write_geometry(1'b0, '0, 1'b1, 16'h0003);
		for (int k = 0; k < 3; k++) send_pixel(pix_t'(k * 127));

		// Random frames; every frame runs to its end before the next one starts.
		random_pixels = 0;
		while (random_pixels < RANDOM_PIXELS) begin
			wide_cut = $urandom_range(15, 1);
			tall_cut = $urandom_range(6, 2);
			if ($urandom_range(99) < 60) begin
				case ($urandom_range(2))
					0: write_geometry(1'b1, pick_width(1'b1), 1'b0, '0);
					1: write_geometry(1'b0, '0, 1'b1, pick_height(1'b1));
					default: write_geometry(1'b1, pick_width(1'b1), 1'b1, pick_height(1'b1));
				endcase
			end
			do begin
				// Cut wide rows short inside row 0 so the line store never serves
				// a column that this frame has not written.
				if (tracker.row_cnt == 0 && tracker.last_col_idx() > 15 &&
						tracker.col_cnt >= wide_cut) begin
					write_geometry(1'b1, pick_width(1'b0), 1'b0, '0);
				end else if (tracker.last_row_idx() > 19 && tracker.row_cnt >= tall_cut) begin
					write_geometry(1'b0, '0, 1'b1, pick_height(1'b0));
				end else if ($urandom_range(79) == 0) begin
					// mid-frame change: width grows only in row 0, shrinks anywhere; height changes anywhere
					if (tracker.row_cnt == 0 && $urandom_range(1))
						write_geometry(1'b1, pick_width(1'b0), 1'b0, '0);
					else if ($urandom_range(1))
						write_geometry(1'b1, {PAD_W'($urandom),
							IMG_W_W'($urandom_range(tracker.last_col_idx()))}, 1'b0, '0);
					else
						write_geometry(1'b0, '0, 1'b1, pick_height(1'b0));
				end
				// plenty of ties and extremes so the sort sees equal values
				case ($urandom_range(9))
					0: pix = '0;
					1: pix = '1;
					2, 3: pix = pix_t'($urandom_range(3) * 85);
					default: pix = pix_t'($urandom);
				endcase
				send_pixel(pix);
				random_pixels++;
				if (random_pixels == 150 || random_pixels == 400) hold_due = 1'b1;
				steady = (random_pixels >= 220 && random_pixels < 320);
			end while (!tracker.at_frame_start());
		end

		steady = 1'b0;
		settle();
		$display("Ran %0d pixels through %0d complete frames, widths 3 to 2048, heights 3 to 65535,",
			tracker.pixels, tracker.frames);
		$display("checked %0d result beats (%0d window medians), %0d mismatches.",
			tracker.beats_seen, tracker.medians, tracker.errors);
		if (tracker.errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

// ===== median_filter_3x3.f =====
+incdir+hdl
hdl/mf3_pkg.sv
hdl/mf3_median.sv
hdl/mf3_front.sv
hdl/mf3_fifo.sv
hdl/mf3_back.sv
hdl/median_filter_3x3.sv
tb/median_filter_3x3_test.sv
